[hw/rtl/qsav_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qsav_pkg
// Shared widths, register codes, types and the arctangent table of the
// quaternion steering angular velocity unit.
// ----------------------------------------------------------------------------
package qsav_pkg;

    localparam int IN_W         = 16;
    localparam int STEP_W       = 16;
    localparam int OUT_W        = 32;
    localparam int PROD_W       = 32;
    localparam int SUM_W        = 34;
    localparam int FRAC_DROP    = 4;
    localparam int DW           = 30;
    localparam int MAG_W        = 29;
    localparam int ROOT_W       = 29;
    localparam int SQ_W         = 2 * ROOT_W;
    localparam int REM_W        = ROOT_W + 2;
    localparam int CW           = 33;
    localparam int CORDIC_STEPS = 31;
    localparam int ATAN_W       = 30;
    localparam int ANG_MAG_W    = 32;
    localparam int HALF_W       = 16;
    localparam int MUL_W        = 45;
    localparam int NUM_W        = 60;
    localparam int DEN_W        = 50;
    localparam int Q_W          = 32;
    localparam int LIN_SHIFT    = 25;
    localparam int EXP_SHIFT    = 5;
    localparam int LANES        = 3;
    localparam int CFG_IDX_W    = 1;

    localparam logic [MAG_W-1:0]  LIN_W_MIN       = 29'd16777;
    localparam logic [STEP_W-1:0] STEP_TIME_RESET = 16'd1092;
    localparam logic [OUT_W-1:0]  OMEGA_MAX       = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0]  OMEGA_MIN       = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_TIME = 1'b0,
        REG_SPIN_MODE = 1'b1
    } t_cfg_reg;

    // Rotation delta in Q.24 after the short-way sign fix.
    typedef struct packed {
        logic signed [DW-1:0] w;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
    } t_delta;

    // atan(2^-i) in Q.30 radians.
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/qsav_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qsav_in_if
// Input channel: a pair of unit quaternions, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qsav_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] from_w;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] from_z;
    logic signed [15:0] to_w;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic signed [15:0] to_z;

    modport source (
        output valid, from_w, from_x, from_y, from_z, to_w, to_x, to_y, to_z,
        input  ready
    );
    modport sink (
        input  valid, from_w, from_x, from_y, from_z, to_w, to_x, to_y, to_z,
        output ready
    );
endinterface
`default_nettype wire

[hw/rtl/qsav_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qsav_out_if
// Output channel: angular velocity in Q24.8 with a saturation flag.
// ----------------------------------------------------------------------------
interface qsav_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] omega_x;
    logic signed [31:0] omega_y;
    logic signed [31:0] omega_z;
    logic               saturated;

    modport source (
        output valid, omega_x, omega_y, omega_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, omega_x, omega_y, omega_z, saturated,
        output ready
    );
endinterface
`default_nettype wire

[hw/rtl/quaternion_steering_angular_velocity_unit.sv]
// Stages from an accepted item to its result: 4 delta stages, 29 square
// root stages, 31 CORDIC stages, 36 scaling and division stages.
// Throughput: one item per cycle; the output register holding a result that
// is not taken freezes the whole pipeline and drops input ready.
// Reset (synchronous, active low) empties the pipeline and loads step_time
// 1092 and spin_mode 0.
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_steering_angular_velocity_unit
// Angular velocity that turns one unit quaternion into another in one step.
// ----------------------------------------------------------------------------
module quaternion_steering_angular_velocity_unit import qsav_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [STEP_W-1:0]     i_cfg_data,
    qsav_in_if.sink                    i_req,
    qsav_out_if.source                 o_rsp
);

    logic [STEP_W-1:0]  r_step_time;
    logic               r_spin_mode;
    logic               w_en;

    logic               d_valid;
    t_delta             d_delta;
    logic [SQ_W-1:0]    d_sq;
    logic               s_valid;
    t_delta             s_delta;
    logic [ROOT_W-1:0]  s_root;
    logic               c_valid;
    t_delta             c_delta;
    logic [ROOT_W-1:0]  c_root;
    logic signed [CW-1:0] c_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= STEP_TIME_RESET;
            r_spin_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_STEP_TIME: r_step_time <= i_cfg_data;
                REG_SPIN_MODE: r_spin_mode <= i_cfg_data[0];
            endcase
        end
    end

    // The pipeline moves whenever the output register is free or being taken.
    assign w_en        = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = w_en;

    qsav_delta u_delta (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_req.valid),
        .i_from_w (i_req.from_w),
        .i_from_x (i_req.from_x),
        .i_from_y (i_req.from_y),
        .i_from_z (i_req.from_z),
        .i_to_w   (i_req.to_w),
        .i_to_x   (i_req.to_x),
        .i_to_y   (i_req.to_y),
        .i_to_z   (i_req.to_z),
        .o_valid  (d_valid),
        .o_delta  (d_delta),
        .o_sq     (d_sq)
    );

    qsav_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (d_valid),
        .i_delta (d_delta),
        .i_sq    (d_sq),
        .o_valid (s_valid),
        .o_delta (s_delta),
        .o_root  (s_root)
    );

    qsav_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_valid),
        .i_delta (s_delta),
        .i_root  (s_root),
        .o_valid (c_valid),
        .o_delta (c_delta),
        .o_root  (c_root),
        .o_ang   (c_ang)
    );

    qsav_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (c_valid),
        .i_delta     (c_delta),
        .i_root      (c_root),
        .i_ang       (c_ang),
        .i_step_time (r_step_time),
        .i_spin_mode (r_spin_mode),
        .o_valid     (o_rsp.valid),
        .o_omega_x   (o_rsp.omega_x),
        .o_omega_y   (o_rsp.omega_y),
        .o_omega_z   (o_rsp.omega_z),
        .o_saturated (o_rsp.saturated)
    );

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.saturated) |->
            (o_rsp.omega_x == signed'(OMEGA_MAX) || o_rsp.omega_x == signed'(OMEGA_MIN) ||
             o_rsp.omega_y == signed'(OMEGA_MAX) || o_rsp.omega_y == signed'(OMEGA_MIN) ||
             o_rsp.omega_z == signed'(OMEGA_MAX) || o_rsp.omega_z == signed'(OMEGA_MIN)))
        else $error("saturated flag without a clamped component");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("input accepted while the pipeline is frozen");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("result presented right after reset");

endmodule
`default_nettype wire

[hw/rtl/qsav_delta.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qsav_delta
// Four stages: quaternion products, delta with short-way fix, squares of
// the vector part, and their sum.
// ----------------------------------------------------------------------------
module qsav_delta import qsav_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire logic signed [IN_W-1:0]  i_from_w,
    input  wire logic signed [IN_W-1:0]  i_from_x,
    input  wire logic signed [IN_W-1:0]  i_from_y,
    input  wire logic signed [IN_W-1:0]  i_from_z,
    input  wire logic signed [IN_W-1:0]  i_to_w,
    input  wire logic signed [IN_W-1:0]  i_to_x,
    input  wire logic signed [IN_W-1:0]  i_to_y,
    input  wire logic signed [IN_W-1:0]  i_to_z,
    output logic                         o_valid,
    output t_delta                       o_delta,
    output logic [SQ_W-1:0]              o_sq
);

    logic [3:0]                r_v;
    logic signed [PROD_W-1:0]  r_p [16];
    logic signed [SUM_W-1:0]   s_w, s_x, s_y, s_z;
    logic signed [SUM_W-1:0]   f_w, f_x, f_y, f_z;
    t_delta                    n_d2, r_d2, r_d3;
    logic signed [2*DW-1:0]    sq_x, sq_y, sq_z;
    logic [SQ_W-1:0]           r_sq_x, r_sq_y, r_sq_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]  <= i_to_w * i_from_w;
            r_p[1]  <= i_to_x * i_from_x;
            r_p[2]  <= i_to_y * i_from_y;
            r_p[3]  <= i_to_z * i_from_z;
            r_p[4]  <= i_from_w * i_to_x;
            r_p[5]  <= i_to_w * i_from_x;
            r_p[6]  <= i_to_y * i_from_z;
            r_p[7]  <= i_to_z * i_from_y;
            r_p[8]  <= i_from_w * i_to_y;
            r_p[9]  <= i_to_w * i_from_y;
            r_p[10] <= i_to_z * i_from_x;
            r_p[11] <= i_to_x * i_from_z;
            r_p[12] <= i_from_w * i_to_z;
            r_p[13] <= i_to_w * i_from_z;
            r_p[14] <= i_to_x * i_from_y;
            r_p[15] <= i_to_y * i_from_x;
        end
    end

    // Delta is formed exactly, flipped to the short way, then floored to Q.24.
    always_comb begin
        s_w = SUM_W'(r_p[0]) + SUM_W'(r_p[1]) + SUM_W'(r_p[2]) + SUM_W'(r_p[3]);
        s_x = SUM_W'(r_p[4]) - SUM_W'(r_p[5]) - SUM_W'(r_p[6]) + SUM_W'(r_p[7]);
        s_y = SUM_W'(r_p[8]) - SUM_W'(r_p[9]) - SUM_W'(r_p[10]) + SUM_W'(r_p[11]);
        s_z = SUM_W'(r_p[12]) - SUM_W'(r_p[13]) - SUM_W'(r_p[14]) + SUM_W'(r_p[15]);
        f_w = s_w[SUM_W-1] ? -s_w : s_w;
        f_x = s_w[SUM_W-1] ? -s_x : s_x;
        f_y = s_w[SUM_W-1] ? -s_y : s_y;
        f_z = s_w[SUM_W-1] ? -s_z : s_z;
        n_d2.w = f_w[SUM_W-1:FRAC_DROP];
        n_d2.x = f_x[SUM_W-1:FRAC_DROP];
        n_d2.y = f_y[SUM_W-1:FRAC_DROP];
        n_d2.z = f_z[SUM_W-1:FRAC_DROP];
    end

    always_comb begin
        sq_x = r_d2.x * r_d2.x;
        sq_y = r_d2.y * r_d2.y;
        sq_z = r_d2.z * r_d2.z;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d2    <= n_d2;
            r_d3    <= r_d2;
            r_sq_x  <= sq_x[SQ_W-1:0];
            r_sq_y  <= sq_y[SQ_W-1:0];
            r_sq_z  <= sq_z[SQ_W-1:0];
            o_delta <= r_d3;
            o_sq    <= r_sq_x + r_sq_y + r_sq_z;
        end
    end

    assign o_valid = r_v[3];

endmodule
`default_nettype wire

[hw/rtl/qsav_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qsav_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qsav_isqrt import qsav_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire t_delta             i_delta,
    input  wire logic [SQ_W-1:0]    i_sq,
    output logic                    o_valid,
    output t_delta                  o_delta,
    output logic [ROOT_W-1:0]       o_root
);

    logic [ROOT_W-1:0] r_v;
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [REM_W-1:0]  p_rem  [ROOT_W];
    logic [REM_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [ROOT_W-1:0] p_root [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];
    logic [SQ_W-1:0]   r_n    [ROOT_W];
    logic [SQ_W-1:0]   p_n    [ROOT_W];
    logic [SQ_W-1:0]   n_n    [ROOT_W];
    t_delta            r_d    [ROOT_W];

    always_comb begin
        p_rem[0]  = '0;
        p_root[0] = '0;
        p_n[0]    = i_sq;
        for (int k = 1; k < ROOT_W; k++) begin
            p_rem[k]  = r_rem[k-1];
            p_root[k] = r_root[k-1];
            p_n[k]    = r_n[k-1];
        end
    end

    // Each stage brings down the next two radicand bits and tries a 1 digit.
    always_comb begin
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        for (int k = 0; k < ROOT_W; k++) begin
            rem_sh = {p_rem[k], p_n[k][SQ_W-1 -: 2]};
            trial  = (REM_W+2)'({p_root[k], 2'b01});
            if (rem_sh >= trial) begin
                n_rem[k]  = REM_W'(rem_sh - trial);
                n_root[k] = {p_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = REM_W'(rem_sh);
                n_root[k] = {p_root[k][ROOT_W-2:0], 1'b0};
            end
            n_n[k] = p_n[k] << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ROOT_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_delta;
            for (int k = 1; k < ROOT_W; k++) begin
                r_d[k] <= r_d[k-1];
            end
            for (int k = 0; k < ROOT_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_n[k]    <= n_n[k];
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_delta = r_d[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];

endmodule
`default_nettype wire

[hw/rtl/qsav_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qsav_cordic
// Pipelined CORDIC vectoring: angle of (w, |v|) in Q.30, one step a stage.
// ----------------------------------------------------------------------------
module qsav_cordic import qsav_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire t_delta             i_delta,
    input  wire logic [ROOT_W-1:0]  i_root,
    output logic                    o_valid,
    output t_delta                  o_delta,
    output logic [ROOT_W-1:0]       o_root,
    output logic signed [CW-1:0]    o_ang
);

    logic [CORDIC_STEPS-1:0] r_v;
    logic signed [CW-1:0]    r_x [CORDIC_STEPS];
    logic signed [CW-1:0]    r_y [CORDIC_STEPS];
    logic signed [CW-1:0]    r_z [CORDIC_STEPS];
    logic signed [CW-1:0]    p_x [CORDIC_STEPS];
    logic signed [CW-1:0]    p_y [CORDIC_STEPS];
    logic signed [CW-1:0]    p_z [CORDIC_STEPS];
    logic signed [CW-1:0]    n_x [CORDIC_STEPS];
    logic signed [CW-1:0]    n_y [CORDIC_STEPS];
    logic signed [CW-1:0]    n_z [CORDIC_STEPS];
    t_delta                  r_d [CORDIC_STEPS];
    logic [ROOT_W-1:0]       r_s [CORDIC_STEPS];

    always_comb begin
        p_x[0] = CW'(i_delta.w);
        p_y[0] = signed'(CW'(i_root));
        p_z[0] = '0;
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            p_x[i] = r_x[i-1];
            p_y[i] = r_y[i-1];
            p_z[i] = r_z[i-1];
        end
    end

    // Arithmetic shifts floor, as the rotation steps require.
    always_comb begin
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] da;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = p_x[i] >>> i;
            dy = p_y[i] >>> i;
            da = signed'(CW'(atan_q30(5'(i))));
            if (p_y[i] > 0) begin
                n_x[i] = p_x[i] + dy;
                n_y[i] = p_y[i] - dx;
                n_z[i] = p_z[i] + da;
            end else if (p_y[i] < 0) begin
                n_x[i] = p_x[i] - dy;
                n_y[i] = p_y[i] + dx;
                n_z[i] = p_z[i] - da;
            end else begin
                n_x[i] = p_x[i];
                n_y[i] = p_y[i];
                n_z[i] = p_z[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[CORDIC_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_delta;
            r_s[0] <= i_root;
            for (int i = 1; i < CORDIC_STEPS; i++) begin
                r_d[i] <= r_d[i-1];
                r_s[i] <= r_s[i-1];
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
                r_z[i] <= n_z[i];
            end
        end
    end

    assign o_valid = r_v[CORDIC_STEPS-1];
    assign o_delta = r_d[CORDIC_STEPS-1];
    assign o_root  = r_s[CORDIC_STEPS-1];
    assign o_ang   = r_z[CORDIC_STEPS-1];

endmodule
`default_nettype wire

[hw/rtl/qsav_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qsav_div
// Scaling and division for three lanes: split multiply, numerator and
// denominator forming, overflow check, 32 restoring division stages and
// the saturating output register.
// ----------------------------------------------------------------------------
module qsav_div import qsav_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire t_delta              i_delta,
    input  wire logic [ROOT_W-1:0]   i_root,
    input  wire logic signed [CW-1:0] i_ang,
    input  wire logic [STEP_W-1:0]   i_step_time,
    input  wire logic                i_spin_mode,
    output logic                     o_valid,
    output logic signed [OUT_W-1:0]  o_omega_x,
    output logic signed [OUT_W-1:0]  o_omega_y,
    output logic signed [OUT_W-1:0]  o_omega_z,
    output logic                     o_saturated
);

    localparam int LAT = Q_W + 4;

    logic [LAT-1:0]          r_v;

    // Stage A
    logic signed [DW-1:0]    a_d [LANES];
    logic [MAG_W-1:0]        a_md [LANES];
    logic                    a_ang_neg;
    logic [ANG_MAG_W-1:0]    a_ma;
    logic [MAG_W-1:0]        a_dw;
    logic [MAG_W-1:0]        a_wc;
    logic [MAG_W-1:0]        a_opnd;
    logic [MAG_W-1:0]        r_a_md [LANES];
    logic [MUL_W-1:0]        r_a_pl [LANES];
    logic [MUL_W-1:0]        r_a_ph [LANES];
    logic [MUL_W-1:0]        r_a_dprod;
    logic [LANES-1:0]        r_a_neg;
    logic                    r_a_zero;
    logic                    r_a_mode;

    // Stage B
    logic [NUM_W-1:0]        r_b_num [LANES];
    logic [DEN_W-1:0]        r_b_den;
    logic [LANES-1:0]        r_b_neg;
    logic                    r_b_zero;

    // Stage C
    logic [DEN_W-1:0]        c_hi [LANES];
    logic [DEN_W-1:0]        r_c_p [LANES];
    logic [Q_W-1:0]          r_c_lo [LANES];
    logic [LANES-1:0]        r_c_ovf;
    logic [DEN_W-1:0]        r_c_den;
    logic [LANES-1:0]        r_c_neg;
    logic                    r_c_zero;

    // Division stages
    logic [DEN_W-1:0]        p_p  [Q_W][LANES];
    logic [Q_W-1:0]          p_lo [Q_W][LANES];
    logic [Q_W-1:0]          p_q  [Q_W][LANES];
    logic [DEN_W-1:0]        p_den [Q_W];
    logic [DEN_W-1:0]        n_p  [Q_W][LANES];
    logic [Q_W-1:0]          n_lo [Q_W][LANES];
    logic [Q_W-1:0]          n_q  [Q_W][LANES];
    logic [DEN_W-1:0]        r_s_p  [Q_W][LANES];
    logic [Q_W-1:0]          r_s_lo [Q_W][LANES];
    logic [Q_W-1:0]          r_s_q  [Q_W][LANES];
    logic [DEN_W-1:0]        r_s_den [Q_W];
    logic [LANES-1:0]        r_s_ovf [Q_W];
    logic [LANES-1:0]        r_s_neg [Q_W];
    logic [Q_W-1:0]          r_s_zero;

    // Output stage
    logic [OUT_W-1:0]        f_om [LANES];
    logic [LANES-1:0]        f_sat;
    logic [OUT_W-1:0]        r_om [LANES];
    logic                    r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[LAT-2:0], i_valid};
        end
    end

    // Stage A: magnitudes, the split angle product and the denominator product.
    always_comb begin
        a_d[0]    = i_delta.x;
        a_d[1]    = i_delta.y;
        a_d[2]    = i_delta.z;
        for (int k = 0; k < LANES; k++) begin
            a_md[k] = MAG_W'(a_d[k][DW-1] ? -a_d[k] : a_d[k]);
        end
        a_ang_neg = i_ang[CW-1];
        a_ma      = ANG_MAG_W'(a_ang_neg ? -i_ang : i_ang);
        a_dw      = MAG_W'(i_delta.w);
        a_wc      = (a_dw < LIN_W_MIN) ? LIN_W_MIN : a_dw;
        a_opnd    = i_spin_mode ? a_wc : i_root;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LANES; k++) begin
                r_a_md[k]  <= a_md[k];
                r_a_pl[k]  <= MUL_W'(a_md[k]) * MUL_W'(a_ma[HALF_W-1:0]);
                r_a_ph[k]  <= MUL_W'(a_md[k]) * MUL_W'(a_ma[ANG_MAG_W-1:HALF_W]);
                r_a_neg[k] <= a_d[k][DW-1] ^ (!i_spin_mode & a_ang_neg);
            end
            r_a_dprod <= MUL_W'(a_opnd) * MUL_W'(i_step_time);
            r_a_zero  <= (i_step_time == '0) | (!i_spin_mode & (i_root == '0));
            r_a_mode  <= i_spin_mode;
        end
    end

    // Stage B: numerator and denominator of either rule.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LANES; k++) begin
                if (r_a_mode) begin
                    r_b_num[k] <= NUM_W'(r_a_md[k]) << LIN_SHIFT;
                end else begin
                    r_b_num[k] <= (NUM_W'(r_a_ph[k]) << HALF_W) + NUM_W'(r_a_pl[k]);
                end
            end
            if (r_a_mode) begin
                r_b_den <= DEN_W'(r_a_dprod);
            end else begin
                r_b_den <= DEN_W'(r_a_dprod) << EXP_SHIFT;
            end
            r_b_neg  <= r_a_neg;
            r_b_zero <= r_a_zero;
        end
    end

    // Stage C: a quotient of 2^32 or more is flagged here and clamped later.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            c_hi[k] = DEN_W'(r_b_num[k][NUM_W-1:Q_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LANES; k++) begin
                r_c_p[k]   <= c_hi[k];
                r_c_lo[k]  <= r_b_num[k][Q_W-1:0];
                r_c_ovf[k] <= (c_hi[k] >= r_b_den);
            end
            r_c_den  <= r_b_den;
            r_c_neg  <= r_b_neg;
            r_c_zero <= r_b_zero;
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            p_p[0][k]  = r_c_p[k];
            p_lo[0][k] = r_c_lo[k];
            p_q[0][k]  = '0;
        end
        p_den[0] = r_c_den;
        for (int j = 1; j < Q_W; j++) begin
            for (int k = 0; k < LANES; k++) begin
                p_p[j][k]  = r_s_p[j-1][k];
                p_lo[j][k] = r_s_lo[j-1][k];
                p_q[j][k]  = r_s_q[j-1][k];
            end
            p_den[j] = r_s_den[j-1];
        end
    end

    // One quotient bit per stage; the partial remainder stays below the divisor.
    always_comb begin
        logic [DEN_W:0] t;
        for (int j = 0; j < Q_W; j++) begin
            for (int k = 0; k < LANES; k++) begin
                t = {p_p[j][k], p_lo[j][k][Q_W-1]};
                if (t >= {1'b0, p_den[j]}) begin
                    n_p[j][k] = DEN_W'(t - {1'b0, p_den[j]});
                    n_q[j][k] = {p_q[j][k][Q_W-2:0], 1'b1};
                end else begin
                    n_p[j][k] = DEN_W'(t);
                    n_q[j][k] = {p_q[j][k][Q_W-2:0], 1'b0};
                end
                n_lo[j][k] = p_lo[j][k] << 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s_den[0]  <= r_c_den;
            r_s_ovf[0]  <= r_c_ovf;
            r_s_neg[0]  <= r_c_neg;
            r_s_zero[0] <= r_c_zero;
            for (int j = 1; j < Q_W; j++) begin
                r_s_den[j]  <= r_s_den[j-1];
                r_s_ovf[j]  <= r_s_ovf[j-1];
                r_s_neg[j]  <= r_s_neg[j-1];
                r_s_zero[j] <= r_s_zero[j-1];
            end
            for (int j = 0; j < Q_W; j++) begin
                for (int k = 0; k < LANES; k++) begin
                    r_s_p[j][k]  <= n_p[j][k];
                    r_s_lo[j][k] <= n_lo[j][k];
                    r_s_q[j][k]  <= n_q[j][k];
                end
            end
        end
    end

    // Sign is applied to the magnitude quotient, which truncates toward zero.
    always_comb begin
        logic [Q_W-1:0] q;
        for (int k = 0; k < LANES; k++) begin
            q        = r_s_q[Q_W-1][k];
            f_sat[k] = 1'b0;
            if (r_s_zero[Q_W-1]) begin
                f_om[k] = '0;
            end else if (!r_s_neg[Q_W-1][k]) begin
                if (r_s_ovf[Q_W-1][k] || q[Q_W-1]) begin
                    f_om[k]  = OMEGA_MAX;
                    f_sat[k] = 1'b1;
                end else begin
                    f_om[k] = q;
                end
            end else begin
                if (r_s_ovf[Q_W-1][k] || (q[Q_W-1] && (q[Q_W-2:0] != '0))) begin
                    f_om[k]  = OMEGA_MIN;
                    f_sat[k] = 1'b1;
                end else begin
                    f_om[k] = -q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LANES; k++) begin
                r_om[k] <= f_om[k];
            end
            r_sat <= |f_sat;
        end
    end

    assign o_valid     = r_v[LAT-1];
    assign o_omega_x   = signed'(r_om[0]);
    assign o_omega_y   = signed'(r_om[1]);
    assign o_omega_z   = signed'(r_om[2]);
    assign o_saturated = r_sat;

endmodule
`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Streams quaternion pairs through the steering angular velocity unit. A
// scoreboard recomputes each angular velocity in fixed point and checks the
// results in order. Step time and spin mode are changed between phases, and
// both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qsav_pkg::*;

    localparam int HOLD_LEN    = 400;
    localparam int DRAIN_WAIT  = 120;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic signed [15:0] fw, fx, fy, fz, tw, tx, ty, tz;
    } t_quat_pair;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic               sat;
    } t_omega;

    class omega_scoreboard;
        t_omega   pending[$];
        int       mismatches;
        longint   step;
        bit       linear;
        longint   atan_tab[CORDIC_STEPS];

        function new();
            longint tab[CORDIC_STEPS] = '{
                843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                128, 64, 32, 16, 8, 4, 2, 1};
            atan_tab   = tab;
            mismatches = 0;
            step       = STEP_TIME_RESET;
            linear     = 1'b0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [STEP_W-1:0] data);
            if (idx == REG_STEP_TIME) step = data;
            else linear = data[0];
        endfunction

        function longint root_floor(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        // Vectoring rotation of (x, y) onto the x axis; returns the angle in Q.30.
        function longint angle_q30(longint y, longint x);
            longint z, dx, dy;
            z = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = x >>> i;
                dy = y >>> i;
                if (y > 0) begin
                    x += dy; y -= dx; z += atan_tab[i];
                end else if (y < 0) begin
                    x -= dy; y += dx; z -= atan_tab[i];
                end
            end
            return z;
        endfunction

        function void note_item(t_quat_pair q);
            longint fw, fx, fy, fz, tw, tx, ty, tz, dw, s, ang, wc;
            longint d[3], om[3];
            longint unsigned sq;
            t_omega r;
            fw = q.fw; fx = q.fx; fy = q.fy; fz = q.fz;
            tw = q.tw; tx = q.tx; ty = q.ty; tz = q.tz;
            om = '{0, 0, 0};
            if (step != 0) begin
                dw   = tw * fw + tx * fx + ty * fy + tz * fz;
                d[0] = fw * tx - tw * fx - (ty * fz - tz * fy);
                d[1] = fw * ty - tw * fy - (tz * fx - tx * fz);
                d[2] = fw * tz - tw * fz - (tx * fy - ty * fx);
                if (dw < 0) begin
                    dw = -dw;
                    for (int k = 0; k < 3; k++) d[k] = -d[k];
                end
                dw = dw >>> FRAC_DROP;
                for (int k = 0; k < 3; k++) d[k] = d[k] >>> FRAC_DROP;
                if (!linear) begin
                    sq = 0;
                    for (int k = 0; k < 3; k++) sq += longint'(d[k] * d[k]);
                    s = root_floor(sq);
                    if (s != 0) begin
                        ang = angle_q30(s, dw);
                        for (int k = 0; k < 3; k++)
                            om[k] = (d[k] * ang) / (s * step * 32);
                    end
                end else begin
                    wc = (dw < longint'(LIN_W_MIN)) ? longint'(LIN_W_MIN) : dw;
                    for (int k = 0; k < 3; k++)
                        om[k] = (d[k] * (64'sd1 <<< LIN_SHIFT)) / (step * wc);
                end
            end
            r.sat = 1'b0;
            for (int k = 0; k < 3; k++) begin
                if (om[k] > 64'sd2147483647) begin
                    om[k] = 64'sd2147483647; r.sat = 1'b1;
                end
                if (om[k] < -64'sd2147483648) begin
                    om[k] = -64'sd2147483648; r.sat = 1'b1;
                end
            end
            r.x = om[0][31:0];
            r.y = om[1][31:0];
            r.z = om[2][31:0];
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(t_omega got);
            t_omega exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result x=%0d y=%0d z=%0d sat=%0b",
                             got.x, got.y, got.z, got.sat);
                return;
            end
            exp_r = pending.pop_front();
            if (got.x !== exp_r.x || got.y !== exp_r.y || got.z !== exp_r.z ||
                    got.sat !== exp_r.sat) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: omega expected %0d %0d %0d sat %0b, got %0d %0d %0d sat %0b",
                             exp_r.x, exp_r.y, exp_r.z, exp_r.sat,
                             got.x, got.y, got.z, got.sat);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [STEP_W-1:0]    i_cfg_data;

    qsav_in_if  req_if();
    qsav_out_if rsp_if();

    quaternion_steering_angular_velocity_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    omega_scoreboard sb = new();

    // 0: sender idles 25%, receiver 75%; 1: the reverse; 2: no idling.
    int idle_mode  = 0;
    int hold_req   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int stall_cnt  = 0;
    bit watch_on   = 1'b0;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_STEP_TIME;
        i_cfg_data     = '0;
        req_if.valid   = 1'b0;
        req_if.from_w  = '0; req_if.from_x = '0; req_if.from_y = '0; req_if.from_z = '0;
        req_if.to_w    = '0; req_if.to_x   = '0; req_if.to_y   = '0; req_if.to_z   = '0;
        rsp_if.ready   = 1'b0;
    end

    // Receiver: random ready, with a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready = 1'b0;
        end else if (idle_mode == 0) begin
            rsp_if.ready = ($urandom_range(0, 99) >= 75);
        end else if (idle_mode == 1) begin
            rsp_if.ready = ($urandom_range(0, 99) >= 25);
        end else begin
            rsp_if.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_omega got;
        t_quat_pair q;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                q.fw = req_if.from_w; q.fx = req_if.from_x;
                q.fy = req_if.from_y; q.fz = req_if.from_z;
                q.tw = req_if.to_w;   q.tx = req_if.to_x;
                q.ty = req_if.to_y;   q.tz = req_if.to_z;
                sb.note_item(q);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got.x   = rsp_if.omega_x;
                got.y   = rsp_if.omega_y;
                got.z   = rsp_if.omega_z;
                got.sat = rsp_if.saturated;
                sb.check_result(got);
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stall_cnt = 0;
            else if (watch_on)
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_pair(t_quat_pair q);
        while (idle_mode == 1 ? ($urandom_range(0, 99) < 75)
                : (idle_mode == 0 ? ($urandom_range(0, 99) < 25) : 1'b0)) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid  = 1'b1;
        req_if.from_w = q.fw; req_if.from_x = q.fx; req_if.from_y = q.fy; req_if.from_z = q.fz;
        req_if.to_w   = q.tw; req_if.to_x   = q.tx; req_if.to_y   = q.ty; req_if.to_z   = q.tz;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    // Wait for every pending result, then let the pipeline run empty.
    task automatic drain();
        req_if.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [STEP_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.set_reg(idx, data);
    endtask

    function automatic logic signed [15:0] to_q14(real v);
        int r;
        r = $rtoi(v * 16384.0 + (v >= 0.0 ? 0.5 : -0.5));
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function automatic t_quat_pair make_pair(int pick);
        t_quat_pair q;
        real a[4], b[4], n, spread;
        if (pick < 10) begin
            // Raw bit patterns, including non-unit and out-of-range values.
            q.fw = 16'($urandom); q.fx = 16'($urandom);
            q.fy = 16'($urandom); q.fz = 16'($urandom);
            q.tw = 16'($urandom); q.tx = 16'($urandom);
            q.ty = 16'($urandom); q.tz = 16'($urandom);
            return q;
        end
        for (int k = 0; k < 4; k++) a[k] = real'($urandom_range(0, 2000)) - 1000.0;
        n = $sqrt(a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3]);
        if (n < 1.0) begin
            a = '{1000.0, 0.0, 0.0, 0.0};
            n = 1000.0;
        end
        for (int k = 0; k < 4; k++) a[k] = a[k] / n;
        case ($urandom_range(0, 3))
            0:       spread = 0.0005;
            1:       spread = 0.02;
            2:       spread = 0.3;
            default: spread = 3.0;
        endcase
        for (int k = 0; k < 4; k++)
            b[k] = a[k] + spread * (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0;
        n = $sqrt(b[0]*b[0] + b[1]*b[1] + b[2]*b[2] + b[3]*b[3]);
        if (n < 1.0e-6) begin
            b = a;
            n = 1.0;
        end
        // The target sign is free; the block must take the short way either way.
        if ($urandom_range(0, 1)) n = -n;
        for (int k = 0; k < 4; k++) b[k] = b[k] / n;
        q.fw = to_q14(a[0]); q.fx = to_q14(a[1]); q.fy = to_q14(a[2]); q.fz = to_q14(a[3]);
        q.tw = to_q14(b[0]); q.tx = to_q14(b[1]); q.ty = to_q14(b[2]); q.tz = to_q14(b[3]);
        return q;
    endfunction

    task automatic run_phase(logic [STEP_W-1:0] step, logic [STEP_W-1:0] mode,
                             int count, int idling, bit hold);
        t_quat_pair q;
        write_reg(REG_STEP_TIME, step);
        write_reg(REG_SPIN_MODE, mode);
        idle_mode = idling;
        for (int i = 0; i < count; i++) begin
            if (hold && i == count / 3) hold_req++;
            q = make_pair($urandom_range(0, 99));
            send_pair(q);
        end
        drain();
    endtask

    initial begin
        t_quat_pair dir[$];
        t_quat_pair q;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        watch_on = 1'b1;
        @(negedge i_clk);

        // Identity to identity: zero vector part.
        dir.insert(dir.size(), '{16384, 0, 0, 0, 16384, 0, 0, 0});
        // Same target as current.
        dir.insert(dir.size(), '{11585, 11585, 0, 0, 11585, 11585, 0, 0});
        // Target on the opposite sign: short-way negation.
        dir.insert(dir.size(), '{16384, 0, 0, 0, -16384, 0, 0, 0});
        dir.insert(dir.size(), '{16384, 0, 0, 0, -11585, -11585, 0, 0});
        // Half turns: delta scalar part zero.
        dir.insert(dir.size(), '{16384, 0, 0, 0, 0, 16384, 0, 0});
        dir.insert(dir.size(), '{16384, 0, 0, 0, 0, 0, 16384, 0});
        dir.insert(dir.size(), '{16384, 0, 0, 0, 0, 0, 0, -16384});
        // Tiny rotations.
        dir.insert(dir.size(), '{16384, 0, 0, 0, 16384, 1, 0, 0});
        dir.insert(dir.size(), '{16384, 0, 0, 0, 16383, 0, -180, 0});
        // Field extremes and full-range raw values.
        dir.insert(dir.size(), '{-16384, 16384, -16384, 16384, 16384, -16384, 16384, -16384});
        dir.insert(dir.size(), '{-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767});
        dir.insert(dir.size(), '{32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767});
        dir.insert(dir.size(), '{0, 0, 0, 0, 0, 0, 0, 0});
        dir.insert(dir.size(), '{-1, -1, -1, -1, -1, -1, -1, -1});
        dir.insert(dir.size(), '{0, 32767, 0, 0, 0, 0, 32767, 0});

        idle_mode = 2;
        foreach (dir[i]) send_pair(dir[i]);
        drain();
        // The same items under the linear rule, with a value whose upper bits must be ignored.
        write_reg(REG_SPIN_MODE, 16'hFFFF);
        foreach (dir[i]) send_pair(dir[i]);
        drain();

        run_phase(16'd1092,  16'd0, 300, 0, 1'b0);
        run_phase(16'd1092,  16'd3, 300, 0, 1'b1);
        run_phase(16'd65535, 16'd2, 250, 1, 1'b0);
        run_phase(16'd1,     16'd1, 250, 1, 1'b0);
        run_phase(16'd0,     16'd0, 100, 1, 1'b0);
        run_phase(16'($urandom), 16'($urandom), 300, 2, 1'b1);
        run_phase(16'($urandom_range(100, 5000)), 16'd1, 300, 2, 1'b0);

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("ERROR: %0d mismatches, %0d results missing",
                     sb.mismatches, sb.pending.size());
            $display("FAIL");
        end
        $finish;
    end
endmodule
